>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL that checks its own logic (the allocator top).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_IMPLIES_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// Types, codes and sizes shared by the bitmap region allocator modules.
// ----------------------------------------------------------------------------
package bra_pkg;

  // Map size and field widths
  localparam int MaxElements = 128;
  localparam int AddrW       = $clog2(MaxElements);
  localparam int IdxW        = 8;
  localparam int CntW        = 8;
  localparam int RegionW     = 7;
  localparam int CmdW        = 3;
  localparam int StatusW     = 2;

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_CHECK     = 3'd0,
    CMD_GET       = 3'd1,
    CMD_PUT       = 3'd2,
    CMD_SET       = 3'd3,
    CMD_CLEAR     = 3'd4,
    CMD_CLEAR_ALL = 3'd5,
    CMD_TEST      = 3'd6
  } cmd_t;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_INVALID = 2'd1;
  localparam logic [StatusW-1:0] ST_NOSPACE = 2'd2;

  // Work that a decoded request still needs
  typedef enum logic [1:0] {
    DEC_DONE,
    DEC_SCAN,
    DEC_FILL,
    DEC_TEST
  } dec_kind_t;

  // Controller states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FILL,
    S_TEST,
    S_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic decode;
    logic scan;
    logic fill;
    logic test_cap;
    logic clr;
    logic finish;
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    dec_kind_t dec_kind;
    logic      is_get;
    logic      scan_hit;
    logic      scan_miss;
    logic      fill_last;
    logic      clr_last;
    logic      out_free;
  } sts_t;

endpackage

>>> rtl/bra_ctrl.sv
// ----------------------------------------------------------------------------
// bra_ctrl
// Sequencer for the allocator: clearing pass, decode, scan, fill, test, finish.
// ----------------------------------------------------------------------------
module bra_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bra_pkg::sts_t  sts,
  output bra_pkg::ctrl_t ctrl
);

  bra_pkg::state_t state;
  bra_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bra_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      bra_pkg::S_INIT: begin
        ctrl.clr = 1'b1;
        if (sts.clr_last) state_next = bra_pkg::S_IDLE;
      end
      bra_pkg::S_IDLE: begin
        if (in_valid) begin
          ctrl.accept = 1'b1;
          state_next  = bra_pkg::S_DECODE;
        end
      end
      bra_pkg::S_DECODE: begin
        ctrl.decode = 1'b1;
        unique case (sts.dec_kind)
          bra_pkg::DEC_SCAN: state_next = bra_pkg::S_SCAN;
          bra_pkg::DEC_FILL: state_next = bra_pkg::S_FILL;
          bra_pkg::DEC_TEST: state_next = bra_pkg::S_TEST;
          default:           state_next = bra_pkg::S_FINISH;
        endcase
      end
      bra_pkg::S_SCAN: begin
        ctrl.scan = 1'b1;
        if (sts.scan_hit) begin
          state_next = sts.is_get ? bra_pkg::S_FILL : bra_pkg::S_FINISH;
        end else if (sts.scan_miss) begin
          state_next = bra_pkg::S_FINISH;
        end
      end
      bra_pkg::S_FILL: begin
        ctrl.fill = 1'b1;
        if (sts.fill_last) state_next = bra_pkg::S_FINISH;
      end
      bra_pkg::S_TEST: begin
        ctrl.test_cap = 1'b1;
        state_next    = bra_pkg::S_FINISH;
      end
      bra_pkg::S_FINISH: begin
        if (sts.out_free) begin
          ctrl.finish = 1'b1;
          state_next  = bra_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bra_pkg::S_INIT;
      end
    endcase
  end

  assign in_stall = (state != bra_pkg::S_IDLE);

endmodule

>>> rtl/bra_datapath.sv
// ----------------------------------------------------------------------------
// bra_datapath
// Used-map memory, request registers, scan and fill pointers, result register.
// ----------------------------------------------------------------------------
module bra_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  bra_pkg::ctrl_t              ctrl,
  output bra_pkg::sts_t               sts,
  input  logic [bra_pkg::CmdW-1:0]    command,
  input  logic [bra_pkg::IdxW-1:0]    start_req,
  input  logic [bra_pkg::CntW-1:0]    count,
  input  logic                        cfg_write_en,
  input  logic [bra_pkg::IdxW-1:0]    cfg_write_data,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [bra_pkg::StatusW-1:0] status,
  output logic [bra_pkg::RegionW-1:0] region_start,
  output logic                        bit_is_set
);

  localparam logic [bra_pkg::IdxW-1:0] MaxTotal = bra_pkg::IdxW'(bra_pkg::MaxElements);
  localparam logic [bra_pkg::IdxW-1:0] LastAddr = bra_pkg::IdxW'(bra_pkg::MaxElements - 1);

  // Used map
  logic mem [bra_pkg::MaxElements];
  logic rdata;

  // Configuration and request registers
  logic [bra_pkg::IdxW-1:0]    cfg_total;
  logic [bra_pkg::CmdW-1:0]    cmd_r;
  logic [bra_pkg::IdxW-1:0]    start_r;
  logic [bra_pkg::CntW-1:0]    cnt_r;

  // Scan and fill state
  logic [bra_pkg::IdxW-1:0]    ptr;
  logic [bra_pkg::IdxW-1:0]    ev_ptr;
  logic                        ev_valid;
  logic [bra_pkg::CntW-1:0]    run;
  logic [bra_pkg::IdxW-1:0]    cand;
  logic [bra_pkg::IdxW:0]      fill_end;
  logic                        fill_val;

  // Result under construction
  logic [bra_pkg::StatusW-1:0] res_status;
  logic [bra_pkg::RegionW-1:0] res_region;
  logic                        res_bit;

  // Decode results
  logic [bra_pkg::IdxW-1:0]    total;
  logic [bra_pkg::IdxW:0]      total9;
  logic [bra_pkg::IdxW:0]      sum;
  logic [bra_pkg::IdxW:0]      put_end;
  logic                        cnt_zero;
  bra_pkg::dec_kind_t          dec_kind;
  logic                        dec_invalid;
  logic [bra_pkg::IdxW-1:0]    dec_start;
  logic [bra_pkg::IdxW:0]      dec_end;
  logic                        dec_val;

  // Scan evaluation
  logic [bra_pkg::CntW-1:0]    run_inc;
  logic                        ev_out;
  logic                        scan_hit;
  logic                        scan_miss;
  logic [bra_pkg::AddrW-1:0]   raddr;

  // Effective total is capped at the map size
  assign total    = (cfg_total > MaxTotal) ? MaxTotal : cfg_total;
  assign total9   = {1'b0, total};
  assign sum      = {1'b0, start_r} + {1'b0, cnt_r};
  assign put_end  = (sum > total9) ? total9 : sum;
  assign cnt_zero = (cnt_r == '0);

  // Classify the request held in the request registers
  always_comb begin
    dec_kind    = bra_pkg::DEC_DONE;
    dec_invalid = 1'b0;
    dec_start   = start_r;
    dec_end     = sum;
    dec_val     = 1'b0;
    unique case (cmd_r) inside
      bra_pkg::CMD_CHECK, bra_pkg::CMD_GET: begin
        if (cnt_zero) dec_invalid = 1'b1;
        else          dec_kind    = bra_pkg::DEC_SCAN;
      end
      bra_pkg::CMD_PUT: begin
        dec_end = put_end;
        if (!cnt_zero && ({1'b0, start_r} < put_end)) dec_kind = bra_pkg::DEC_FILL;
      end
      bra_pkg::CMD_SET, bra_pkg::CMD_CLEAR: begin
        dec_val = (cmd_r == bra_pkg::CMD_SET);
        if (cnt_zero || (sum > total9)) dec_invalid = 1'b1;
        else                            dec_kind    = bra_pkg::DEC_FILL;
      end
      bra_pkg::CMD_CLEAR_ALL: begin
        dec_start = '0;
        dec_end   = total9;
        if (total != '0) dec_kind = bra_pkg::DEC_FILL;
      end
      bra_pkg::CMD_TEST: begin
        if (start_r < total) dec_kind = bra_pkg::DEC_TEST;
      end
      default: begin
        dec_invalid = 1'b1;
      end
    endcase
  end

  // Evaluate the element read in the previous scan cycle
  assign run_inc   = run + 1'b1;
  assign ev_out    = (ev_ptr >= total);
  assign scan_hit  = ev_valid && !ev_out && !rdata && (run_inc == cnt_r);
  assign scan_miss = ev_valid && ev_out;

  // Read the test bit during decode, otherwise the scan pointer
  assign raddr = ctrl.decode ? start_r[bra_pkg::AddrW-1:0] : ptr[bra_pkg::AddrW-1:0];

  // Status toward the controller
  always_comb begin
    sts.dec_kind  = dec_kind;
    sts.is_get    = (cmd_r == bra_pkg::CMD_GET);
    sts.scan_hit  = scan_hit;
    sts.scan_miss = scan_miss;
    sts.fill_last = (({1'b0, ptr} + 1'b1) == fill_end);
    sts.clr_last  = (ptr == LastAddr);
    sts.out_free  = !out_valid || !out_stall;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_total <= MaxTotal;
    end else if (cfg_write_en) begin
      cfg_total <= cfg_write_data;
    end
  end

  // Map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.fill || ctrl.clr) begin
      mem[ptr[bra_pkg::AddrW-1:0]] <= ctrl.clr ? 1'b0 : fill_val;
    end
    rdata <= mem[raddr];
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd_r   <= command;
      start_r <= start_req;
      cnt_r   <= count;
    end
  end

  // Walk pointer: clearing pass, scan and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (ctrl.decode) begin
      ptr <= dec_start;
    end else if (ctrl.scan && scan_hit) begin
      ptr <= cand;
    end else if (ctrl.scan || ctrl.fill || ctrl.clr) begin
      ptr <= ptr + 1'b1;
    end
  end

  // Fill bounds and value
  always_ff @(posedge clk) begin
    if (ctrl.decode) begin
      fill_end <= dec_end;
      fill_val <= dec_val;
    end else if (ctrl.scan && scan_hit) begin
      fill_end <= {1'b0, cand} + {1'b0, cnt_r};
      fill_val <= 1'b1;
    end
  end

  // Track the free run and its candidate start
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (ctrl.decode) begin
      ev_valid <= 1'b0;
    end else if (ctrl.scan) begin
      ev_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.decode) begin
      run  <= '0;
      cand <= start_r;
    end else if (ctrl.scan) begin
      ev_ptr <= ptr;
      if (ev_valid && !ev_out) begin
        if (rdata) begin
          run  <= '0;
          cand <= ev_ptr + 1'b1;
        end else begin
          run <= run_inc;
        end
      end
    end
  end

  // Build the result
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      res_status <= bra_pkg::ST_OK;
      res_region <= '0;
      res_bit    <= 1'b0;
    end else if (ctrl.decode) begin
      if (dec_invalid) res_status <= bra_pkg::ST_INVALID;
    end else if (ctrl.scan) begin
      if (scan_hit)  res_region <= cand[bra_pkg::RegionW-1:0];
      if (scan_miss) res_status <= bra_pkg::ST_NOSPACE;
    end else if (ctrl.test_cap) begin
      res_bit <= rdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      status       <= res_status;
      region_start <= res_region;
      bit_is_set   <= res_bit;
    end
  end

endmodule

>>> rtl/bitmap_region_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_region_allocator
// Contiguous-region allocator over a used-map of resource elements.
// ----------------------------------------------------------------------------
// Channel   Handshake                   Payload
// request   in_valid / in_stall         command, start_req, count
// result    out_valid / out_stall       status, region_start, bit_is_set
// config    cfg_write_en                cfg_write_data (total elements)
//
// One request at a time; the map is a single-port-write, registered-read memory
// walked one element per cycle. Check scans from the start index for a free run
// of count elements and stops at the first fit or at the total; get then marks
// the region it found. Put, set, clear and clear-all walk their range; test
// reads one bit; a request with nothing to do goes straight to its result.
// After reset a clearing pass over all 128 map elements runs with in_stall high.
// A held result in the output register does not block the next request; only
// the final load waits for the output register to be free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_region_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bra_pkg::CmdW-1:0]    command,
  input  logic [bra_pkg::IdxW-1:0]    start_req,
  input  logic [bra_pkg::CntW-1:0]    count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bra_pkg::StatusW-1:0] status,
  output logic [bra_pkg::RegionW-1:0] region_start,
  output logic                        bit_is_set,
  input  logic                        cfg_write_en,
  input  logic [bra_pkg::IdxW-1:0]    cfg_write_data
);

  bra_pkg::ctrl_t ctrl;
  bra_pkg::sts_t  sts;
  logic           result_failed;

  // Sequencer
  bra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctrl     (ctrl)
  );

  // Map, pointers and result registers
  bra_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .sts            (sts),
    .command        (command),
    .start_req      (start_req),
    .count          (count),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .region_start   (region_start),
    .bit_is_set     (bit_is_set)
  );

  assign result_failed = out_valid && (status != bra_pkg::ST_OK);

  // Busy right after taking a request
  `ASSERT_IMPLIES_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // Loading a result always presents it
  `ASSERT_IMPLIES_NEXT(a_finish_presents, clk, rst, ctrl.finish, out_valid)

  // A failed request carries no region start
  `ASSERT_IMPLIES(a_region_zero_on_fail, clk, rst, result_failed, region_start == '0)

  // A set test bit only comes with an ok status
  `ASSERT_IMPLIES(a_bit_only_ok, clk, rst, out_valid && bit_is_set, status == bra_pkg::ST_OK)

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap region allocator. A behavioral copy of
// the used-map predicts every result at the moment its request is accepted.
// Results are compared in order against that prediction. Stimulus: directed
// corner cases, total-register checks, random traffic under several totals,
// a long output stall that fills the block, and a gapless random stream.
// ----------------------------------------------------------------------------
module testbench;

  // Code that no command uses
  localparam logic [bra_pkg::CmdW-1:0] CmdUnused = 3'd7;

  typedef struct packed {
    logic [bra_pkg::StatusW-1:0] status;
    logic [bra_pkg::RegionW-1:0] region;
    logic                        bit_val;
  } alloc_result_t;

  logic                         clk            = 1'b0;
  logic                         rst            = 1'b1;
  logic                         in_valid       = 1'b0;
  logic                         in_stall;
  logic [bra_pkg::CmdW-1:0]     command        = '0;
  logic [bra_pkg::IdxW-1:0]     start_req      = '0;
  logic [bra_pkg::CntW-1:0]     count          = '0;
  logic                         out_valid;
  logic                         out_stall      = 1'b0;
  logic [bra_pkg::StatusW-1:0]  status;
  logic [bra_pkg::RegionW-1:0]  region_start;
  logic                         bit_is_set;
  logic                         cfg_write_en   = 1'b0;
  logic [bra_pkg::IdxW-1:0]     cfg_write_data = '0;

  // Predicted state of the allocator
  logic [bra_pkg::MaxElements-1:0] model_map   = '0;
  int unsigned                     model_total = 128;

  alloc_result_t pending_results[$];
  int unsigned   error_count       = 0;
  bit            gaps_on           = 1'b1;
  int unsigned   sink_hold_cycles  = 0;

  bitmap_region_allocator dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .start_req      (start_req),
    .count          (count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .region_start   (region_start),
    .bit_is_set     (bit_is_set),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin : watchdog
    #3_200_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned model_limit();
    return (model_total < bra_pkg::MaxElements) ? model_total : bra_pkg::MaxElements;
  endfunction

  // Lowest index at or after from with len free bits below lim; lim if none
  function automatic int unsigned find_free_run(int unsigned from, int unsigned len,
                                                int unsigned lim);
    int unsigned idx;
    int unsigned k;
    bit          clear_run;
    for (idx = from; idx + len <= lim; idx++) begin
      clear_run = 1'b1;
      for (k = 0; k < len; k++) begin
        if (model_map[idx + k]) clear_run = 1'b0;
      end
      if (clear_run) return idx;
    end
    return lim;
  endfunction

  function automatic void fill_map(int unsigned a, int unsigned b, logic v);
    int unsigned i;
    for (i = a; i < b && i < bra_pkg::MaxElements; i++) model_map[i] = v;
  endfunction

  function automatic alloc_result_t apply_request(logic [bra_pkg::CmdW-1:0] op,
                                                  int unsigned first,
                                                  int unsigned len);
    alloc_result_t r;
    int unsigned   lim;
    int unsigned   pos;
    int unsigned   stop;
    r = '0;
    r.status = bra_pkg::ST_OK;
    lim = model_limit();
    case (op) inside
      bra_pkg::CMD_CHECK, bra_pkg::CMD_GET: begin
        if (len == 0) begin
          r.status = bra_pkg::ST_INVALID;
        end else begin
          pos = find_free_run(first, len, lim);
          if (pos >= lim) begin
            r.status = bra_pkg::ST_NOSPACE;
          end else begin
            r.region = pos[bra_pkg::RegionW-1:0];
            if (op == bra_pkg::CMD_GET) fill_map(pos, pos + len, 1'b1);
          end
        end
      end
      bra_pkg::CMD_PUT: begin
        // Clip the release to the usable part of the map
        stop = first + len;
        if (stop > lim) stop = lim;
        if (len != 0 && first < stop) fill_map(first, stop, 1'b0);
      end
      bra_pkg::CMD_SET, bra_pkg::CMD_CLEAR: begin
        if (len == 0 || first + len > lim) r.status = bra_pkg::ST_INVALID;
        else fill_map(first, first + len, (op == bra_pkg::CMD_SET));
      end
      bra_pkg::CMD_CLEAR_ALL: fill_map(0, lim, 1'b0);
      bra_pkg::CMD_TEST: begin
        if (first < lim) r.bit_val = model_map[first];
      end
      default: r.status = bra_pkg::ST_INVALID;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Compare outputs first, then predict the request accepted at this edge
  always @(posedge clk) begin : scoreboard
    alloc_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, status %0d", status));
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
          if (region_start !== want.region)
            report_mismatch($sformatf("region_start %0d, want %0d", region_start,
                                      want.region));
          if (bit_is_set !== want.bit_val)
            report_mismatch($sformatf("bit_is_set %0b, want %0b", bit_is_set,
                                      want.bit_val));
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(apply_request(command, 32'(start_req), 32'(count)));
    end
  end

  // Drive out_stall: random short bursts, or one long hold when requested
  initial begin : result_sink
    int unsigned burst;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles != 0) begin
        out_stall <= 1'b1;
        while (sink_hold_cycles != 0) begin
          @(posedge clk);
          sink_hold_cycles--;
        end
        out_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Offer one request and hold it until accepted
  task automatic send_request(logic [bra_pkg::CmdW-1:0] op, logic [bra_pkg::IdxW-1:0] first,
                              logic [bra_pkg::CntW-1:0] len);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= op;
    start_req <= first;
    count     <= len;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_idle(int unsigned settle);
    in_valid <= 1'b0;
    // Let the last accepted request reach the scoreboard queue
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write the total only once the block has drained
  task automatic write_total(logic [bra_pkg::IdxW-1:0] value);
    wait_for_idle(8);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    model_total = 32'(value);
  endtask

  // Mostly well-formed requests inside the usable range, some noise
  task automatic send_random_request();
    int unsigned              lim;
    int unsigned              top;
    int unsigned              sel;
    logic [bra_pkg::CmdW-1:0] op;
    logic [bra_pkg::IdxW-1:0] first;
    logic [bra_pkg::CntW-1:0] len;
    lim   = model_limit();
    top   = (lim > 0) ? lim - 1 : 0;
    sel   = $urandom_range(0, 99);
    first = bra_pkg::IdxW'($urandom_range(0, top));
    if ($urandom_range(0, 7) == 0) len = bra_pkg::CntW'($urandom_range(1, (lim > 0) ? lim : 1));
    else len = bra_pkg::CntW'($urandom_range(1, 12));
    if (sel < 30)      op = bra_pkg::CMD_GET;
    else if (sel < 52) op = bra_pkg::CMD_PUT;
    else if (sel < 62) op = bra_pkg::CMD_CHECK;
    else if (sel < 72) op = bra_pkg::CMD_TEST;
    else if (sel < 80) op = bra_pkg::CMD_SET;
    else if (sel < 87) op = bra_pkg::CMD_CLEAR;
    else if (sel < 89) op = bra_pkg::CMD_CLEAR_ALL;
    else begin
      // Any code and any field value
      op    = bra_pkg::CmdW'($urandom_range(0, 7));
      first = bra_pkg::IdxW'($urandom_range(0, 255));
      len   = bra_pkg::CntW'($urandom_range(0, 255));
    end
    // Keep most set and clear ranges inside the total
    if ((op == bra_pkg::CMD_SET || op == bra_pkg::CMD_CLEAR) && sel < 89 &&
        int'(first) + int'(len) > lim)
      len = bra_pkg::CntW'(lim - first);
    send_request(op, first, len);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_basic_commands();
    send_request(bra_pkg::CMD_CHECK, 0, 1);
    send_request(bra_pkg::CMD_GET, 0, 4);
    send_request(bra_pkg::CMD_TEST, 3, 0);
    send_request(bra_pkg::CMD_TEST, 4, 0);
    send_request(bra_pkg::CMD_CHECK, 0, 0);
    send_request(bra_pkg::CMD_GET, 9, 0);
    send_request(bra_pkg::CMD_GET, 0, 255);
    send_request(bra_pkg::CMD_GET, 0, 128);
    send_request(bra_pkg::CMD_PUT, 2, 0);
    send_request(bra_pkg::CMD_PUT, 0, 255);
    send_request(bra_pkg::CMD_SET, 120, 8);
    send_request(bra_pkg::CMD_SET, 121, 8);
    send_request(bra_pkg::CMD_CLEAR, 255, 255);
    send_request(bra_pkg::CMD_CLEAR, 124, 4);
    send_request(bra_pkg::CMD_TEST, 255, 255);
    send_request(bra_pkg::CMD_TEST, 121, 0);
    send_request(CmdUnused, 0, 1);
    send_request(bra_pkg::CMD_GET, 200, 1);
    send_request(bra_pkg::CMD_CLEAR_ALL, 0, 0);
    send_request(bra_pkg::CMD_GET, 0, 128);
    send_request(bra_pkg::CMD_TEST, 127, 0);
    send_request(bra_pkg::CMD_CLEAR_ALL, 255, 255);
  endtask

  task automatic test_total_register();
    // Nothing usable with a zero total
    write_total(0);
    send_request(bra_pkg::CMD_CHECK, 0, 1);
    send_request(bra_pkg::CMD_SET, 0, 1);
    send_request(bra_pkg::CMD_TEST, 0, 0);
    send_request(bra_pkg::CMD_PUT, 0, 4);
    write_total(1);
    send_request(bra_pkg::CMD_GET, 0, 1);
    send_request(bra_pkg::CMD_CHECK, 0, 1);
    // Bits past a shrunk total survive and come back when it grows
    write_total(255);
    send_request(bra_pkg::CMD_SET, 10, 10);
    write_total(12);
    send_request(bra_pkg::CMD_TEST, 15, 0);
    send_request(bra_pkg::CMD_CLEAR_ALL, 0, 0);
    write_total(128);
    send_request(bra_pkg::CMD_TEST, 15, 0);
    send_request(bra_pkg::CMD_TEST, 5, 0);
  endtask

  task automatic test_random_traffic();
    int unsigned phase_total[5];
    int unsigned n;
    phase_total = '{128, 8, 255, 0, 45};
    phase_total[3] = $urandom_range(1, 255);
    foreach (phase_total[p]) begin
      write_total(bra_pkg::IdxW'(phase_total[p]));
      for (n = 0; n < 110; n++) send_random_request();
    end
  endtask

  // Hold off the result side so the block fills and stalls its input
  task automatic test_output_backpressure();
    int unsigned n;
    write_total(128);
    sink_hold_cycles = 300;
    for (n = 0; n < 12; n++) begin
      if (n[0]) send_request(bra_pkg::CMD_TEST, bra_pkg::IdxW'($urandom_range(0, 127)), 0);
      else send_request(bra_pkg::CMD_GET, bra_pkg::IdxW'($urandom_range(0, 127)),
                        bra_pkg::CntW'($urandom_range(1, 4)));
    end
  endtask

  task automatic test_steady_stream();
    int unsigned n;
    wait_for_idle(8);
    gaps_on = 1'b0;
    for (n = 0; n < 90; n++) send_random_request();
  endtask

  initial begin : run
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_basic_commands();
    test_total_register();
    test_random_traffic();
    test_output_backpressure();
    test_steady_stream();
    wait_for_idle(300);
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
